// ----- rtl/atsc_pkg.sv -----
// ----------------------------------------------------------------------------
// atsc_pkg
// Types, token codes, keyword table and character class helpers shared by
// the assembly token scanner and its result queue.
// ----------------------------------------------------------------------------
package atsc_pkg;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_WORD    = 3'd3,
    MODE_STRING  = 3'd4
  } scan_mode_t;

  // token kind codes
  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_INT     = 6'd1;
  localparam logic [5:0] K_DOUBLE  = 6'd2;
  localparam logic [5:0] K_STRING  = 6'd3;
  localparam logic [5:0] K_LABEL   = 6'd4;
  localparam logic [5:0] K_KW_BASE = 6'd5;
  localparam logic [5:0] K_COLON   = 6'd32;
  localparam logic [5:0] K_LPAREN  = 6'd33;
  localparam logic [5:0] K_RPAREN  = 6'd34;
  localparam logic [5:0] K_COMMA   = 6'd35;
  localparam logic [5:0] K_MINUS   = 6'd36;
  localparam logic [5:0] K_STAR    = 6'd37;
  localparam logic [5:0] K_AT      = 6'd38;
  localparam logic [5:0] K_DOLLAR  = 6'd39;
  localparam logic [5:0] K_INVALID = 6'd40;

  // character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PCT    = 8'h25;

  // result queue depth (entries)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // keyword table: text right-aligned, first character in the highest used byte
  localparam int NUM_KW = 27;
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    ".global", ".text", ".data", ".string", ".quad",
    "push", "pop", "int", "mov", "sub", "call", "ret", "lea", "cmp", "je",
    "%rax", "%rbx", "%rcx", "%rdx", "%rdi", "%rsi", "%r8", "%r9", "%r10",
    "%rsp", "%rbp", "%rip"
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd7, 3'd5, 3'd5, 3'd7, 3'd5,
    3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd2,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4
  };

  // one result token
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_DOT) || (c == CH_UNDER);
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h3A:   k = K_COLON;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h2C:   k = K_COMMA;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_STAR;
      8'h40:   k = K_AT;
      8'h24:   k = K_DOLLAR;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  // narrow the candidate set by the character at position pos
  function automatic logic [NUM_KW-1:0] kw_match(input logic [NUM_KW-1:0] mask,
                                                 input logic [2:0] pos,
                                                 input logic pos_ok,
                                                 input logic [7:0] c);
    logic [NUM_KW-1:0] res;
    int idx;
    res = '0;
    for (int i = 0; i < NUM_KW; i++) begin
      idx = int'(KW_LEN[i]) - 1 - int'(pos);
      if (mask[i] && pos_ok && (pos < KW_LEN[i]) && (idx >= 0))
        res[i] = (KW_TEXT[i][8*idx +: 8] == c);
    end
    return res;
  endfunction

  // first candidate whose length matches, else label
  function automatic logic [5:0] word_kind(input logic [NUM_KW-1:0] mask,
                                           input logic [2:0] len,
                                           input logic len_ok);
    logic [5:0] k;
    k = K_LABEL;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (mask[i] && len_ok && (KW_LEN[i] == len))
        k = K_KW_BASE + 6'(i);
    end
    return k;
  endfunction

endpackage

// ----- rtl/atsc_out_queue.sv -----
// ----------------------------------------------------------------------------
// atsc_out_queue
// Result queue: up to two tokens in a cycle, one out a cycle on out_ready.
// ----------------------------------------------------------------------------
module atsc_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  atsc_pkg::tok_t    push_tok0,
  input  atsc_pkg::tok_t    push_tok1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output atsc_pkg::tok_t    out_tok
);

  localparam int QCNT_W_EXT = atsc_pkg::QCNT_W + 1;

  atsc_pkg::tok_t                 mem_r [atsc_pkg::QDEPTH];
  logic [atsc_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [atsc_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [atsc_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_tok   = mem_r[rd_ptr_r];
  assign room2     = (count_r <= atsc_pkg::QCNT_W'(atsc_pkg::QDEPTH - 2));

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + atsc_pkg::QPTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + atsc_pkg::QPTR_W'(pop);
    count_nxt  = count_r + atsc_pkg::QCNT_W'(push_cnt) - atsc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage writes
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0)
      mem_r[wr_ptr_r] <= push_tok0;
    if (push_cnt == 2'd2)
      mem_r[wr_ptr_r + atsc_pkg::QPTR_W'(1)] <= push_tok1;
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |->
      ((QCNT_W_EXT'(count_r) + QCNT_W_EXT'(push_cnt)) <= QCNT_W_EXT'(atsc_pkg::QDEPTH)))
    else $error("result queue overflow");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_nxt)))
    else $error("result queue fill count slipped");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

// ----- rtl/assembly_token_scanner.sv -----
// ----------------------------------------------------------------------------
// assembly_token_scanner
// Character-at-a-time assembly lexer: one source byte or end marker per
// request in, up to two tokens out per request, with line and column of each token.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser        | tlast
//  in_     | in  | [7:0] char_code                | end_of_input | -
//  out_    | out | [5:0] token_kind,              | -            | last_of_run
//          |     | [21:6] lexeme_length,          |              |
//          |     | [37:22] start_line,            |              |
//          |     | [53:38] start_column, rest 0   |              |
//
//  one input request a cycle while in_tready is high; the scan state
//  updates in the accepting cycle and its tokens (none, one or two) are
//  registered in a four-entry result queue, one token a cycle out on ready.
//  in_tready is high while the queue has room for two tokens.
//  synchronous active-low reset returns to idle with all counters at zero.
// ----------------------------------------------------------------------------
module assembly_token_scanner #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // kind, length, line, column, zero pad
  output logic        out_tlast   // last_of_run
);

  localparam int CB = COUNTER_BITS;

  atsc_pkg::scan_mode_t       mode_r, mode_nxt;
  logic                       dot_r, dot_nxt;
  logic [atsc_pkg::NUM_KW-1:0] cand_r, cand_nxt;
  logic [CB-1:0]              len_r, len_nxt;
  logic [CB-1:0]              line_r, line_nxt;
  logic [CB-1:0]              col_r, col_nxt;
  logic [CB-1:0]              tline_r, tline_nxt;
  logic [CB-1:0]              tcol_r, tcol_nxt;

  logic                       accept;
  logic [7:0]                 c;
  logic [CB-1:0]              col1;
  logic                       pos_ok;
  logic                       rescan;
  logic                       t0_vld, t1_vld;
  atsc_pkg::tok_t             t0, t1, q0, q1;
  logic [1:0]                 push_cnt;
  atsc_pkg::tok_t             out_tok;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == {CB{1'b1}}) ? v : v + CB'(1);
  endfunction

  assign accept = in_tvalid && in_tready;
  assign c      = in_tdata;
  assign col1   = sat_inc(col_r);
  assign pos_ok = (len_r < CB'(8));

  // scan step: mode update and token generation
  always_comb begin
    mode_nxt  = mode_r;
    dot_nxt   = dot_r;
    cand_nxt  = cand_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    col_nxt   = col1;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    rescan    = 1'b0;
    t0_vld    = 1'b0;
    t1_vld    = 1'b0;
    t0        = '0;
    t1        = '0;
    t0.len    = 16'(len_r);
    t0.line   = 16'(tline_r);
    t0.col    = 16'(tcol_r);

    if (in_tuser) begin
      // end of input: flush pending token, then eof
      unique case (mode_r)
        atsc_pkg::MODE_NUMBER: begin
          t0_vld  = 1'b1;
          t0.kind = dot_r ? atsc_pkg::K_DOUBLE : atsc_pkg::K_INT;
        end
        atsc_pkg::MODE_WORD: begin
          t0_vld  = 1'b1;
          t0.kind = atsc_pkg::word_kind(cand_r, len_r[2:0], pos_ok);
        end
        atsc_pkg::MODE_STRING: begin
          t0_vld  = 1'b1;
          t0.kind = atsc_pkg::K_INVALID;
        end
        default: ;
      endcase
      t1_vld   = 1'b1;
      t1.kind  = atsc_pkg::K_EOF;
      t1.len   = 16'd0;
      t1.line  = 16'(line_r);
      t1.col   = 16'(col1);
      mode_nxt = atsc_pkg::MODE_IDLE;
      dot_nxt  = 1'b0;
      cand_nxt = '0;
      len_nxt  = '0;
    end else begin
      unique case (mode_r)
        atsc_pkg::MODE_COMMENT: begin
          if (c == atsc_pkg::CH_LF) begin
            line_nxt = sat_inc(line_r);
            col_nxt  = '0;
            mode_nxt = atsc_pkg::MODE_IDLE;
          end
        end
        atsc_pkg::MODE_STRING: begin
          if (c == atsc_pkg::CH_QUOTE) begin
            t0_vld   = 1'b1;
            t0.kind  = atsc_pkg::K_STRING;
            mode_nxt = atsc_pkg::MODE_IDLE;
          end else begin
            len_nxt = sat_inc(len_r);
          end
        end
        atsc_pkg::MODE_NUMBER: begin
          if (atsc_pkg::is_digit(c)) begin
            len_nxt = sat_inc(len_r);
          end else if ((c == atsc_pkg::CH_DOT) && !dot_r) begin
            dot_nxt = 1'b1;
            len_nxt = sat_inc(len_r);
          end else begin
            t0_vld   = 1'b1;
            t0.kind  = dot_r ? atsc_pkg::K_DOUBLE : atsc_pkg::K_INT;
            mode_nxt = atsc_pkg::MODE_IDLE;
            dot_nxt  = 1'b0;
            rescan   = 1'b1;
          end
        end
        atsc_pkg::MODE_WORD: begin
          if (atsc_pkg::is_word_char(c)) begin
            cand_nxt = atsc_pkg::kw_match(cand_r, len_r[2:0], pos_ok, c);
            len_nxt  = sat_inc(len_r);
          end else begin
            t0_vld   = 1'b1;
            t0.kind  = atsc_pkg::word_kind(cand_r, len_r[2:0], pos_ok);
            mode_nxt = atsc_pkg::MODE_IDLE;
            cand_nxt = '0;
            rescan   = 1'b1;
          end
        end
        default: begin
          mode_nxt = atsc_pkg::MODE_IDLE;
          rescan   = 1'b1;
        end
      endcase

      // scan the character afresh from idle
      if (rescan) begin
        if (c == atsc_pkg::CH_LF) begin
          line_nxt = sat_inc(line_r);
          col_nxt  = '0;
        end else if ((c == atsc_pkg::CH_SPACE) || (c == atsc_pkg::CH_TAB) ||
                     (c == atsc_pkg::CH_CR)) begin
          // blank
        end else if (c == atsc_pkg::CH_HASH) begin
          mode_nxt = atsc_pkg::MODE_COMMENT;
        end else if (atsc_pkg::is_digit(c)) begin
          mode_nxt  = atsc_pkg::MODE_NUMBER;
          len_nxt   = CB'(1);
          tline_nxt = line_r;
          tcol_nxt  = col1;
          dot_nxt   = 1'b0;
        end else if (atsc_pkg::is_alpha(c) || (c == atsc_pkg::CH_DOT) ||
                     (c == atsc_pkg::CH_UNDER) || (c == atsc_pkg::CH_PCT)) begin
          mode_nxt  = atsc_pkg::MODE_WORD;
          len_nxt   = CB'(1);
          tline_nxt = line_r;
          tcol_nxt  = col1;
          dot_nxt   = 1'b0;
          cand_nxt  = atsc_pkg::kw_match({atsc_pkg::NUM_KW{1'b1}}, 3'd0, 1'b1, c);
        end else if (c == atsc_pkg::CH_QUOTE) begin
          mode_nxt  = atsc_pkg::MODE_STRING;
          len_nxt   = '0;
          tline_nxt = line_r;
          tcol_nxt  = col1;
          dot_nxt   = 1'b0;
        end else begin
          t1_vld  = 1'b1;
          t1.kind = atsc_pkg::punct_kind(c);
          t1.len  = 16'd1;
          t1.line = 16'(line_r);
          t1.col  = 16'(col1);
        end
      end
    end
  end

  // order tokens into queue slots and mark the last one
  always_comb begin
    q0 = t0_vld ? t0 : t1;
    q1 = t1;
    q0.last = !(t0_vld && t1_vld);
    q1.last = 1'b1;
    push_cnt = '0;
    if (accept)
      push_cnt = 2'(t0_vld) + 2'(t1_vld);
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= atsc_pkg::MODE_IDLE;
      dot_r   <= 1'b0;
      cand_r  <= '0;
      len_r   <= '0;
      line_r  <= '0;
      col_r   <= '0;
      tline_r <= '0;
      tcol_r  <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      dot_r   <= dot_nxt;
      cand_r  <= cand_nxt;
      len_r   <= len_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
    end
  end

  // result queue
  atsc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_tok0 (q0),
    .push_tok1 (q1),
    .room2     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (out_tok)
  );

  assign out_tdata = {2'b00, out_tok.col, out_tok.line, out_tok.len, out_tok.kind};
  assign out_tlast = out_tok.last;

  // checks
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tok.kind == atsc_pkg::K_EOF)) |-> out_tlast)
    else $error("eof token not last of its run");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tok.kind <= atsc_pkg::K_INVALID))
    else $error("token kind out of range");

  a_eoi_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser) |=> ((mode_r == atsc_pkg::MODE_IDLE) && (len_r == '0)))
    else $error("scanner not idle after end of input");

  a_eoi_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser) |-> (push_cnt != 2'd0))
    else $error("end of input gave no token");

endmodule
